// File: rtl/rgb_convolution_3x3_clamped_macros.svh
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_clamped_macros
// assertion helpers for the rgb convolution block
// ----------------------------------------------------------------------------
`ifndef RGB_CONVOLUTION_3X3_CLAMPED_MACROS_SVH
`define RGB_CONVOLUTION_3X3_CLAMPED_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RC3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rc3 check failed");

// next-cycle implication
`define RC3_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rc3 check failed");

`endif

// File: rtl/rc3_pkg.sv
// ----------------------------------------------------------------------------
// rc3_pkg
// shared constants, types and helpers of the rgb 3x3 convolution block
// ----------------------------------------------------------------------------
`default_nettype none

package rc3_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COEF_FRAC_BITS = 12;
    localparam int COEF_W         = 16;
    localparam int CHAN_W         = 8;
    localparam int PIX_W          = 3 * CHAN_W;
    localparam int CHAN_MAX       = 255;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int WID_W          = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W          = $clog2(MAX_HEIGHT);
    localparam int HGT_W          = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W         = $clog2(MAX_WIDTH + 2);
    localparam int PROD_W         = COEF_W + CHAN_W + 1;
    localparam int RSUM_W         = PROD_W + 2;
    localparam int SUM_W          = PROD_W + 4;
    localparam int FIFO_DEPTH     = 8;
    localparam int FPTR_W         = $clog2(FIFO_DEPTH);
    localparam int FCNT_W         = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH     = 3'd0,
        CFG_FRAME_HEIGHT    = 3'd1,
        CFG_KERNEL_IS_THREE = 3'd2,
        CFG_COEF_TOP        = 3'd3,
        CFG_COEF_MIDDLE     = 3'd4,
        CFG_COEF_BOTTOM     = 3'd5
    } t_cfg_idx;

    // item handed from the input stage to the line store stage
    typedef struct packed {
        logic             valid;
        logic             is_pix;
        logic             emit;
        logic             direct;
        logic [8:0]       mask;
        logic             last;
        logic [PIX_W-1:0] px;
        logic [COL_W-1:0] addr;
    } t_issue;

    // neighbourhood ready for the multiply stage
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [8:0]            mask;
        logic [8:0][PIX_W-1:0] win;
    } t_snap;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_result;

    // truncate toward zero and clamp to the channel range
    function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = s >>> COEF_FRAC_BITS;
        if (s < 0) begin
            return '0;
        end else if (q >= SUM_W'(CHAN_MAX)) begin
            return CHAN_W'(CHAN_MAX);
        end else begin
            return q[CHAN_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/rgb_convolution_3x3_clamped.sv
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_clamped
// streaming rgb 3x3 / 1x1 convolution with zero border and clamped output
// ----------------------------------------------------------------------------
// takes one pixel transfer per clock in raster order and convolves each colour
// channel with a signed q4.12 kernel; neighbours outside the frame count as
// zero, sums are truncated toward zero and clamped to 0..255. in 3x3 mode an
// output trails its input by frame_width+1 pixels and drain transfers (cmd=1)
// flush the rest of the frame; in 1x1 mode each pixel gives its own output.
// from input transfer to output valid the line store is read at the transfer
// edge, followed in order by the window, multiply, row sum, total/clamp and
// result queue write registers. the sustained rate is one item per clock,
// set by the single read/write port pair of the line store memory; an
// eight-entry result queue absorbs output stalls and input ready drops only
// when every entry is reserved for a waiting or in-flight result.
// the line store needs no clearing pass after reset. configuration must be
// written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_convolution_3x3_clamped_macros.svh"

module rgb_convolution_3x3_clamped
    import rc3_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input pixel channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_cmd,
    input  wire logic [7:0]        i_in_red,
    input  wire logic [7:0]        i_in_green,
    input  wire logic [7:0]        i_in_blue,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_red,
    output logic [7:0]             o_out_green,
    output logic [7:0]             o_out_blue,
    output logic                   o_frame_last,
    // configuration write channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [47:0]       i_cfg_data
);

    // configuration registers
    logic [10:0]         r_frame_width;
    logic [12:0]         r_frame_height;
    logic                r_kernel_is_three;
    logic [47:0]         r_coef_top, r_coef_mid, r_coef_bot;

    // position and bookkeeping
    logic [COL_W-1:0]    r_in_col, n_in_col;
    logic [ROW_W-1:0]    r_in_row, n_in_row;
    logic [COL_W-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0]    r_out_row, n_out_row;
    logic [PEND_W-1:0]   r_pending, n_pending;
    logic [FCNT_W-1:0]   r_credit, n_credit;

    logic [WID_W-1:0]    w_eff;
    logic [HGT_W-1:0]    h_eff;
    logic [PEND_W:0]     lag, pend_inc;
    logic [WID_W-1:0]    cz, in_cz, k_nxt;
    logic [HGT_W-1:0]    rz, in_rz;
    logic [2:0]          row_ok, col_ok;
    logic                is_pix, drain_ok, take, emit, in_xfer, out_xfer;
    logic [COL_W-1:0]    drain_addr;
    t_issue              iss;
    t_snap               snap;
    t_result             res, head;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_credit < FCNT_W'(FIFO_DEPTH));
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;

    // register writes; out-of-list indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width     <= 11'd1024;
            r_frame_height    <= 13'd1;
            r_kernel_is_three <= 1'b1;
            r_coef_top        <= '0;
            r_coef_mid        <= 48'h0000_1000_0000;
            r_coef_bot        <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:     r_frame_width     <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT:    r_frame_height    <= i_cfg_data[12:0];
                CFG_KERNEL_IS_THREE: r_kernel_is_three <= i_cfg_data[0];
                CFG_COEF_TOP:        r_coef_top        <= i_cfg_data;
                CFG_COEF_MIDDLE:     r_coef_mid        <= i_cfg_data;
                CFG_COEF_BOTTOM:     r_coef_bot        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size, zero reads as one, large values saturate
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WID_W'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HGT_W'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HGT_W'(r_frame_height);
        end
    end

    // input stage: decide what the transfer does and step the counters
    always_comb begin
        is_pix   = !i_cmd;
        lag      = r_kernel_is_three ? (PEND_W+1)'(w_eff) + (PEND_W+1)'(1) : '0;
        pend_inc = (PEND_W+1)'(r_pending) + (PEND_W+1)'(1);
        drain_ok = (r_pending != '0) && (r_in_col == '0) && (r_in_row == '0);
        take     = is_pix || drain_ok;
        emit     = is_pix ? (pend_inc > lag) : drain_ok;

        // output position and border masks
        cz    = WID_W'(r_out_col);
        rz    = HGT_W'(r_out_row);
        k_nxt = cz + WID_W'(1);
        drain_addr = (k_nxt >= w_eff) ? '0 : k_nxt[COL_W-1:0];
        row_ok[0] = (rz != '0) && ((rz - HGT_W'(1)) < h_eff);
        row_ok[1] = rz < h_eff;
        row_ok[2] = (rz + HGT_W'(1)) < h_eff;
        col_ok[0] = (cz != '0) && ((cz - WID_W'(1)) < w_eff);
        col_ok[1] = cz < w_eff;
        col_ok[2] = (cz + WID_W'(1)) < w_eff;

        iss.valid  = in_xfer && take;
        iss.is_pix = is_pix;
        iss.emit   = emit;
        iss.direct = is_pix && !r_kernel_is_three;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                iss.mask[r*3+c] = r_kernel_is_three ? (row_ok[r] && col_ok[c])
                                                    : (r == 1 && c == 1);
            end
        end
        iss.last = (rz == h_eff - HGT_W'(1)) && (cz == w_eff - WID_W'(1));
        iss.px   = {i_in_blue, i_in_green, i_in_red};
        iss.addr = is_pix ? r_in_col : drain_addr;

        // next counter values
        in_cz     = WID_W'(r_in_col) + WID_W'(1);
        in_rz     = HGT_W'(r_in_row) + HGT_W'(1);
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pending = r_pending;
        if (in_xfer && is_pix) begin
            if (in_cz >= w_eff) begin
                n_in_col = '0;
                n_in_row = (in_rz >= h_eff) ? '0 : in_rz[ROW_W-1:0];
            end else begin
                n_in_col = in_cz[COL_W-1:0];
            end
            n_pending = emit ? r_pending : pend_inc[PEND_W-1:0];
        end else if (in_xfer && drain_ok) begin
            n_pending = r_pending - PEND_W'(1);
        end
        if (in_xfer && take && emit) begin
            if (k_nxt >= w_eff) begin
                n_out_col = '0;
                n_out_row = (rz + HGT_W'(1) >= h_eff) ? '0
                          : ROW_W'(rz + HGT_W'(1));
            end else begin
                n_out_col = k_nxt[COL_W-1:0];
            end
        end

        // queue room reserved per result in flight
        n_credit = r_credit + FCNT_W'(iss.valid && emit) - FCNT_W'(out_xfer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
            r_credit  <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pending <= n_pending;
            r_credit  <= n_credit;
        end
    end

    rc3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_iss   (iss),
        .o_snap  (snap)
    );

    rc3_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap     (snap),
        .i_coef_top (r_coef_top),
        .i_coef_mid (r_coef_mid),
        .i_coef_bot (r_coef_bot),
        .o_res      (res)
    );

    rc3_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_pop   (out_xfer),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_out_red    = head.red;
    assign o_out_green  = head.green;
    assign o_out_blue   = head.blue;
    assign o_frame_last = head.last;

    // reserved room never exceeds the queue
    `RC3_ASSERT_IMP(a_credit_bound, 1'b1, r_credit <= FCNT_W'(FIFO_DEPTH))
    // a waiting result always holds a reservation
    `RC3_ASSERT_IMP(a_out_reserved, o_out_valid, r_credit != '0)
    // a transfer with no result and no output transfer leaves the reservation alone
    `RC3_ASSERT_NXT(a_credit_hold, in_xfer && !(take && emit) && !out_xfer, r_credit == $past(r_credit))

endmodule

`default_nettype wire

// File: rtl/rc3_window.sv
// ----------------------------------------------------------------------------
// rc3_window
// line store memory with forwarding, and the 3x3 window register
// ----------------------------------------------------------------------------
`default_nettype none

module rc3_window
    import rc3_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_issue i_iss,
    output t_snap       o_snap
);

    // each entry holds {upper row, lower row}
    logic [2*PIX_W-1:0]    mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]    r_rd;
    logic [2*PIX_W-1:0]    r_fwd_data;
    logic                  r_fwd;
    t_issue                r_iss;
    logic [8:0][PIX_W-1:0] r_win;
    logic [8:0][PIX_W-1:0] n_win;
    logic [8:0][PIX_W-1:0] snap_win;
    logic [2*PIX_W-1:0]    line;
    logic [2:0][PIX_W-1:0] col;
    logic                  wr_en;
    t_snap                 r_snap;

    assign wr_en = r_iss.valid && r_iss.is_pix;
    assign line  = r_fwd ? r_fwd_data : r_rd;

    always_comb begin
        col[0] = line[2*PIX_W-1:PIX_W];
        col[1] = line[PIX_W-1:0];
        col[2] = r_iss.is_pix ? r_iss.px : '0;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3+0] = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
            n_win[r*3+2] = col[r];
        end
        // 1x1 pixels take the incoming pixel as centre
        snap_win = n_win;
        if (r_iss.direct) begin
            snap_win[4] = r_iss.px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_iss.valid) begin
            r_rd <= mem[i_iss.addr];
        end
        if (wr_en) begin
            mem[r_iss.addr] <= {col[1], r_iss.px};
        end
        r_fwd_data <= {col[1], r_iss.px};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss.valid  <= 1'b0;
            r_fwd        <= 1'b0;
            r_win        <= '0;
            r_snap.valid <= 1'b0;
        end else begin
            r_iss <= i_iss;
            r_fwd <= wr_en && i_iss.valid && (i_iss.addr == r_iss.addr);
            if (r_iss.valid) begin
                r_win <= n_win;
            end
            r_snap.valid <= r_iss.valid && r_iss.emit;
        end
        r_snap.last <= r_iss.last;
        r_snap.mask <= r_iss.mask;
        r_snap.win  <= snap_win;
    end

    assign o_snap = r_snap;

endmodule

`default_nettype wire

// File: rtl/rc3_mac.sv
// ----------------------------------------------------------------------------
// rc3_mac
// products, row sums, total and clamp, three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module rc3_mac
    import rc3_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_snap               i_snap,
    input  wire logic [3*COEF_W-1:0] i_coef_top,
    input  wire logic [3*COEF_W-1:0] i_coef_mid,
    input  wire logic [3*COEF_W-1:0] i_coef_bot,
    output t_result                  o_res
);

    logic signed [COEF_W-1:0]   coef_v [9];
    logic signed [CHAN_W:0]     pix_v  [9][3];
    logic signed [PROD_W-1:0]   r_prod [9][3];
    logic signed [RSUM_W-1:0]   r_rsum [3][3];
    logic signed [SUM_W-1:0]    total  [3];
    logic                       r_a_valid, r_b_valid;
    logic                       r_a_last, r_b_last;
    t_result                    r_res;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            if (!i_snap.mask[i]) begin
                coef_v[i] = '0;
            end else if (i < 3) begin
                coef_v[i] = i_coef_top[(i%3)*COEF_W +: COEF_W];
            end else if (i < 6) begin
                coef_v[i] = i_coef_mid[(i%3)*COEF_W +: COEF_W];
            end else begin
                coef_v[i] = i_coef_bot[(i%3)*COEF_W +: COEF_W];
            end
            for (int ch = 0; ch < 3; ch++) begin
                pix_v[i][ch] = $signed({1'b0, i_snap.win[i][ch*CHAN_W +: CHAN_W]});
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            total[ch] = SUM_W'(r_rsum[0][ch]) + SUM_W'(r_rsum[1][ch])
                      + SUM_W'(r_rsum[2][ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_prod[i][ch] <= PROD_W'(coef_v[i] * pix_v[i][ch]);
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_rsum[r][ch] <= RSUM_W'(r_prod[r*3][ch]) + RSUM_W'(r_prod[r*3+1][ch])
                               + RSUM_W'(r_prod[r*3+2][ch]);
            end
        end
        r_a_last    <= i_snap.last;
        r_b_last    <= r_a_last;
        r_res.last  <= r_b_last;
        r_res.red   <= clamp_chan(total[0]);
        r_res.green <= clamp_chan(total[1]);
        r_res.blue  <= clamp_chan(total[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_a_valid   <= i_snap.valid;
            r_b_valid   <= r_a_valid;
            r_res.valid <= r_b_valid;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// File: rtl/rc3_ofifo.sv
// ----------------------------------------------------------------------------
// rc3_ofifo
// result queue in front of the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module rc3_ofifo
    import rc3_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_res,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_result      o_head
);

    t_result             mem [FIFO_DEPTH];
    logic [FPTR_W-1:0]   r_wp, r_rp;
    logic [FCNT_W-1:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_head  = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_res.valid) begin
                r_wp <= r_wp + FPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FPTR_W'(1);
            end
            r_cnt <= r_cnt + FCNT_W'(i_res.valid) - FCNT_W'(i_pop);
        end
    end

endmodule

`default_nettype wire
